/* sv/sorted_list_insert_remove_macros.svh */
// assertion helpers, sampled on clk and quiet during rst
`ifndef SORTED_LIST_INSERT_REMOVE_MACROS_SVH
`define SORTED_LIST_INSERT_REMOVE_MACROS_SVH

// condition holds at every edge
`define SLI_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("sli assertion failed");

// antecedent implies consequent in the same cycle
`define SLI_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sli assertion failed");

// antecedent implies consequent in the next cycle
`define SLI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sli assertion failed");

`endif

/* sv/sli_pkg.sv */
`default_nettype none

package sli_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int ECOUNT_W     = 5;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic                idle;
    logic                done;
    logic [STATUS_W-1:0] status;
  } sli_result_t;

endpackage

`default_nettype wire

/* sv/sli_engine.sv */
`default_nettype none

module sli_engine #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic                            cmd,
  input  wire logic signed [sli_pkg::DATA_W-1:0] value,
  input  wire logic                            take,
  output sli_pkg::sli_result_t                 res,
  output logic [CW-1:0]                        count
);

  `include "sorted_list_insert_remove_macros.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_WRKEY = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                            state;
  logic                                  op;
  logic signed [sli_pkg::DATA_W-1:0]     key;
  logic [AW-1:0]                         rd_addr;
  logic                                  issuing;
  logic                                  rd_vld;
  logic [AW-1:0]                         rd_idx;
  logic signed [sli_pkg::DATA_W-1:0]     rdata;
  logic                                  found;
  logic [AW-1:0]                         ins_pos;
  logic [sli_pkg::STATUS_W-1:0]          status;

  logic signed [sli_pkg::DATA_W-1:0]     mem [CAPACITY];

  logic                                  we;
  logic [AW-1:0]                         waddr;
  logic signed [sli_pkg::DATA_W-1:0]     wdata;
  logic [CW-1:0]                         cnt_m1;
  logic [AW-1:0]                         last_idx;
  logic                                  le_key;
  logic                                  eq_key;
  logic                                  issue_last;

  // shared compare unit
  assign le_key   = (rdata <= key);
  assign eq_key   = (rdata == key);
  assign cnt_m1   = count - CW'(1);
  assign last_idx = cnt_m1[AW-1:0];
  assign issue_last = (op == sli_pkg::CMD_INSERT) ? (rd_addr == '0) : (rd_addr == last_idx);

  always_comb begin
    we    = 1'b0;
    waddr = rd_idx;
    wdata = rdata;
    unique case (state)
      S_RUN: begin
        if (rd_vld) begin
          if (op == sli_pkg::CMD_INSERT) begin
            // shift toward the tail while the entry is not greater
            we    = le_key;
            waddr = rd_idx + AW'(1);
          end else begin
            // close the gap behind the removed entry
            we    = found;
            waddr = rd_idx - AW'(1);
          end
        end
      end
      S_WRKEY: begin
        we    = 1'b1;
        waddr = ins_pos;
        wdata = key;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata  <= mem[rd_addr];
    rd_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      issuing <= 1'b0;
      rd_vld  <= 1'b0;
      found   <= 1'b0;
      status  <= sli_pkg::ST_DONE;
    end else begin
      unique case (state)
        S_IDLE: begin
          rd_vld <= 1'b0;
          if (start) begin
            key   <= value;
            op    <= cmd;
            found <= 1'b0;
            if (cmd == sli_pkg::CMD_INSERT) begin
              if (count == CW'(CAPACITY)) begin
                status <= sli_pkg::ST_FULL;
                state  <= S_DONE;
              end else if (count == '0) begin
                ins_pos <= '0;
                state   <= S_WRKEY;
              end else begin
                rd_addr <= last_idx;
                issuing <= 1'b1;
                state   <= S_RUN;
              end
            end else begin
              if (count == '0) begin
                status <= sli_pkg::ST_NOT_FOUND;
                state  <= S_DONE;
              end else begin
                rd_addr <= '0;
                issuing <= 1'b1;
                state   <= S_RUN;
              end
            end
          end
        end
        S_RUN: begin
          rd_vld <= issuing;
          if (issuing) begin
            if (issue_last) begin
              issuing <= 1'b0;
            end else if (op == sli_pkg::CMD_INSERT) begin
              rd_addr <= rd_addr - AW'(1);
            end else begin
              rd_addr <= rd_addr + AW'(1);
            end
          end
          if (rd_vld) begin
            if (op == sli_pkg::CMD_INSERT) begin
              if (!le_key) begin
                ins_pos <= rd_idx + AW'(1);
                issuing <= 1'b0;
                rd_vld  <= 1'b0;
                state   <= S_WRKEY;
              end else if (rd_idx == '0) begin
                ins_pos <= '0;
                issuing <= 1'b0;
                rd_vld  <= 1'b0;
                state   <= S_WRKEY;
              end
            end else begin
              if (eq_key) begin
                found <= 1'b1;
              end
              if (rd_idx == last_idx) begin
                issuing <= 1'b0;
                rd_vld  <= 1'b0;
                state   <= S_DONE;
                if (found || eq_key) begin
                  count  <= count - CW'(1);
                  status <= sli_pkg::ST_DONE;
                end else begin
                  status <= sli_pkg::ST_NOT_FOUND;
                end
              end
            end
          end
        end
        S_WRKEY: begin
          count  <= count + CW'(1);
          status <= sli_pkg::ST_DONE;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.idle   = (state == S_IDLE);
  assign res.done   = (state == S_DONE);
  assign res.status = status;

  `SLI_ASSERT_ALWAYS(a_count_bound, count <= CW'(CAPACITY))
  `SLI_ASSERT_IMPL(a_read_in_run, rd_vld, state == S_RUN)
  `SLI_ASSERT_IMPL(a_full_on_insert, state == S_DONE && status == sli_pkg::ST_FULL,
                   op == sli_pkg::CMD_INSERT && count == CW'(CAPACITY))
  `SLI_ASSERT_NEXT(a_wrkey_grows, state == S_WRKEY, count == $past(count) + CW'(1))

endmodule

`default_nettype wire

/* sv/sorted_list_insert_remove.sv */
// channel  | handshake          | payload
// in       | in_valid/in_ready  | cmd, value
// out      | out_valid/out_ready| status, entry_count, is_empty
// result is registered once the walk ends, with one read and compare per entry visited:
// insert walks from the tail down to its slot, remove walks every stored entry; an insert
// into an empty list, an insert into a full list or a remove from an empty list needs no read
// in_ready is high only while the list walker is idle; the next item enters after the result
// a finished result sits in the output register; the next item may enter meanwhile
// rst is synchronous and empties the list
`default_nettype none

module sorted_list_insert_remove #(
  parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                cmd,
  input  wire logic signed [sli_pkg::DATA_W-1:0]   value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [sli_pkg::STATUS_W-1:0]             status,
  output logic [sli_pkg::ECOUNT_W-1:0]             entry_count,
  output logic                                     is_empty
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  sli_pkg::sli_result_t res;
  logic [CW-1:0]        count;
  logic                 take;
  logic [31:0]          count_ext;

  assign in_ready  = res.idle;
  assign take      = !out_valid || out_ready;
  assign count_ext = 32'(count);

  sli_engine #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .start (in_valid && in_ready),
    .cmd   (cmd),
    .value (value),
    .take  (take),
    .res   (res),
    .count (count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.done && take) begin
      out_valid   <= 1'b1;
      status      <= res.status;
      entry_count <= count_ext[sli_pkg::ECOUNT_W-1:0];
      is_empty    <= (count == '0);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* dv/sorted_list_insert_remove_test.sv */
`default_nettype none

module sorted_list_insert_remove_test;

  localparam int LIST_CAP = sli_pkg::CAPACITY_DEF;
  localparam int N_RANDOM = 600;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 60;
  localparam logic signed [sli_pkg::DATA_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [sli_pkg::DATA_W-1:0] VAL_MIN = 32'sh80000000;

  typedef struct packed {
    logic [sli_pkg::STATUS_W-1:0] status;
    logic [sli_pkg::ECOUNT_W-1:0] count;
    logic                         empty;
  } list_result_t;

  typedef struct {
    bit           typed;
    list_result_t want;
  } item_tag_t;

  typedef struct {
    logic                              cmd;
    logic signed [sli_pkg::DATA_W-1:0] value;
    bit                                typed;
    logic [sli_pkg::STATUS_W-1:0]      status;
    logic [sli_pkg::ECOUNT_W-1:0]      count;
    logic                              empty;
  } dir_row_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic                              cmd = sli_pkg::CMD_INSERT;
  logic signed [sli_pkg::DATA_W-1:0] value = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic [sli_pkg::STATUS_W-1:0]      status;
  logic [sli_pkg::ECOUNT_W-1:0]      entry_count;
  logic                              is_empty;

  logic signed [sli_pkg::DATA_W-1:0] held_vals[$];
  item_tag_t                         item_tags[$];
  list_result_t                      expected_results[$];
  int                                errors = 0;
  int                                quiet_cycles = 0;
  bit                                steady = 1'b0;

  sorted_list_insert_remove #(.CAPACITY(LIST_CAP)) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .entry_count(entry_count),
    .is_empty   (is_empty)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // descending list, equal values go in front of their equals
  function automatic list_result_t sorted_apply(logic op,
                                                logic signed [sli_pkg::DATA_W-1:0] v);
    list_result_t r;
    int pos;
    r.status = sli_pkg::ST_DONE;
    pos = 0;
    if (op == sli_pkg::CMD_INSERT) begin
      if (held_vals.size() >= LIST_CAP) begin
        r.status = sli_pkg::ST_FULL;
      end else begin
        while (pos < held_vals.size() && held_vals[pos] > v) pos++;
        held_vals.insert(pos, v);
      end
    end else begin
      while (pos < held_vals.size() && held_vals[pos] != v) pos++;
      if (pos >= held_vals.size()) r.status = sli_pkg::ST_NOT_FOUND;
      else held_vals.delete(pos);
    end
    r.count = sli_pkg::ECOUNT_W'(held_vals.size());
    r.empty = (held_vals.size() == 0);
    return r;
  endfunction

  task automatic send_item(logic op, logic signed [sli_pkg::DATA_W-1:0] v, item_tag_t tag);
    if (!steady && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    item_tags.push_back(tag);
    in_valid <= 1'b1;
    cmd      <= op;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 15);
  end

  // accepted item: update the predictor and queue what should come out
  always @(posedge clk) begin
    list_result_t r;
    item_tag_t    tag;
    if (!rst && in_valid && in_ready) begin
      r = sorted_apply(cmd, value);
      tag = item_tags.pop_front();
      expected_results.push_back(tag.typed ? tag.want : r);
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: item out with none expected: status %0d count %0d empty %0d",
                 $time, status, entry_count, is_empty);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          errors++;
        end
        if (entry_count !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                   entry_count);
          errors++;
        end
        if (is_empty !== want.empty) begin
          $display("%0t: is_empty expected %0d actual %0d", $time, want.empty, is_empty);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dir_row_t                          rows[25];
    item_tag_t                         tag;
    logic                              op;
    logic signed [sli_pkg::DATA_W-1:0] v;
    int                                insert_pct;
    int                                pick;

    rows = '{
      '{sli_pkg::CMD_REMOVE, 0,       1'b1, sli_pkg::ST_NOT_FOUND, 5'd0,  1'b1},
      '{sli_pkg::CMD_INSERT, VAL_MAX, 1'b1, sli_pkg::ST_DONE,      5'd1,  1'b0},
      '{sli_pkg::CMD_INSERT, VAL_MIN, 1'b1, sli_pkg::ST_DONE,      5'd2,  1'b0},
      '{sli_pkg::CMD_INSERT, 0,       1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0},
      '{sli_pkg::CMD_INSERT, 0,       1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0},
      '{sli_pkg::CMD_INSERT, -1,      1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0},
      '{sli_pkg::CMD_INSERT, 1,       1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0},
      '{sli_pkg::CMD_REMOVE, 5,       1'b1, sli_pkg::ST_NOT_FOUND, 5'd6,  1'b0},
      '{sli_pkg::CMD_REMOVE, 0,       1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0},
      '{sli_pkg::CMD_INSERT, 100,     1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0},
      '{sli_pkg::CMD_INSERT, 200,     1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0},
      '{sli_pkg::CMD_INSERT, -100,    1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0},
      '{sli_pkg::CMD_INSERT, -200,    1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0},
      '{sli_pkg::CMD_INSERT, 7,       1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0},
      '{sli_pkg::CMD_INSERT, 7,       1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0},
      '{sli_pkg::CMD_INSERT, 3,       1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0},
      '{sli_pkg::CMD_INSERT, -3,      1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0},
      '{sli_pkg::CMD_INSERT, 1000,    1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0},
      '{sli_pkg::CMD_INSERT, -1000,   1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0},
      '{sli_pkg::CMD_INSERT, 12345,   1'b1, sli_pkg::ST_DONE,      5'd16, 1'b0},
      '{sli_pkg::CMD_INSERT, 42,      1'b1, sli_pkg::ST_FULL,      5'd16, 1'b0},
      '{sli_pkg::CMD_REMOVE, VAL_MAX, 1'b1, sli_pkg::ST_DONE,      5'd15, 1'b0},
      '{sli_pkg::CMD_REMOVE, VAL_MIN, 1'b1, sli_pkg::ST_DONE,      5'd14, 1'b0},
      '{sli_pkg::CMD_REMOVE, VAL_MIN, 1'b1, sli_pkg::ST_NOT_FOUND, 5'd14, 1'b0},
      '{sli_pkg::CMD_REMOVE, 7,       1'b0, sli_pkg::ST_DONE,      5'd0,  1'b0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      tag.typed = rows[i].typed;
      tag.want  = '{rows[i].status, rows[i].count, rows[i].empty};
      send_item(rows[i].cmd, rows[i].value, tag);
    end

    // bursts that fill the list, bursts that drain it and balanced bursts
    tag.typed = 1'b0;
    tag.want  = '0;
    insert_pct = 50;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 15;
        endcase
      end
      steady = (n >= 250 && n < 370);
      op = ($urandom_range(99) < insert_pct) ? sli_pkg::CMD_INSERT : sli_pkg::CMD_REMOVE;
      pick = $urandom_range(99);
      if (pick < 35 && held_vals.size() != 0) begin
        v = held_vals[$urandom_range(held_vals.size() - 1)];
      end else if (pick < 55) begin
        v = $signed($urandom_range(8)) - 4;
      end else if (pick < 65) begin
        case ($urandom_range(3))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = 0;
          default: v = -1;
        endcase
      end else begin
        v = $urandom;
      end
      send_item(op, v, tag);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: results outstanding expected 0 actual %0d", $time,
               expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
